[sv/bba_pkg.sv]
package bba_pkg;

    // request kinds
    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_ALIGN = 2'd1;
    localparam logic [1:0] KIND_FREE  = 2'd2;
    localparam logic [1:0] KIND_INIT  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOBLK   = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    // width of order values and counters
    localparam int ORD_W = 6;
    // width of the heap size register
    localparam int CFG_W = 5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [16:0] request_size;
        logic [16:0] align_size;
        logic [15:0] block_offset;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] result_offset;
    } out_word_t;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT_SETUP,
        OP_CLR,
        OP_ALLOC_SETUP,
        OP_K_INC,
        OP_TAKE,
        OP_UNL_RD,
        OP_UNL_WR,
        OP_SPLIT,
        OP_PUSH_A,
        OP_PUSH_B,
        OP_FREE_SETUP,
        OP_FCHK_READ,
        OP_MERGE_INIT,
        OP_MRG_READ,
        OP_MRG_TAKE,
        OP_PUSH_SET,
        OP_ST_ERR1,
        OP_ST_ERR2,
        OP_ST_RES,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    // datapath status flags seen by the controller
    typedef struct packed {
        logic kind_init;
        logic kind_free;
        logic alloc_bad;
        logic free_bad;
        logic k_end;
        logic k_last;
        logic head_nz;
        logic tag_nz;
        logic tag_hit;
        logic split_more;
        logic clr_last;
    } stat_t;

    // ceiling of log2(x): smallest c with 2**c >= x
    function automatic logic [ORD_W-1:0] ceil_log2(input logic [16:0] x);
        logic [16:0]      xm;
        logic [ORD_W-1:0] c;
        xm = x - 17'd1;
        c  = '0;
        if (x > 17'd1) begin
            for (int i = 0; i < 17; i++) begin
                if (xm[i]) begin
                    c = ORD_W'(i + 1);
                end
            end
        end
        return c;
    endfunction

endpackage

[sv/bba_ram.sv]
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/bba_ctrl.sv]
module bba_ctrl
    import bba_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [15:0] {
        S_CLR_RST  = 16'h0001,
        S_IDLE     = 16'h0002,
        S_DECODE   = 16'h0004,
        S_CLR_INIT = 16'h0008,
        S_SEARCH   = 16'h0010,
        S_UNL_RD   = 16'h0020,
        S_UNL_WR   = 16'h0040,
        S_SPLIT    = 16'h0080,
        S_PUSH_A   = 16'h0100,
        S_PUSH_B   = 16'h0200,
        S_FCHK0    = 16'h0400,
        S_FCHK_RD  = 16'h0800,
        S_FCHK_TST = 16'h1000,
        S_MRG_RD   = 16'h2000,
        S_MRG_TST  = 16'h4000,
        S_OUT      = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    dp_op_t op;

    // sequencing
    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        case (state_reg)
            S_CLR_RST: begin
                op = OP_CLR;
                if (stat.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    op         = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.kind_init) begin
                    op         = OP_INIT_SETUP;
                    state_next = S_CLR_INIT;
                end else if (stat.kind_free) begin
                    if (stat.free_bad) begin
                        op         = OP_ST_ERR2;
                        state_next = S_OUT;
                    end else begin
                        op         = OP_FREE_SETUP;
                        state_next = S_FCHK0;
                    end
                end else if (stat.alloc_bad) begin
                    op         = OP_ST_ERR1;
                    state_next = S_OUT;
                end else begin
                    op         = OP_ALLOC_SETUP;
                    state_next = S_SEARCH;
                end
            end
            S_CLR_INIT: begin
                op = OP_CLR;
                if (stat.clr_last) state_next = S_PUSH_A;
            end
            S_SEARCH: begin
                if (stat.k_end) begin
                    op         = OP_ST_ERR1;
                    state_next = S_OUT;
                end else if (stat.head_nz) begin
                    op         = OP_TAKE;
                    state_next = S_UNL_RD;
                end else begin
                    op = OP_K_INC;
                end
            end
            S_UNL_RD: begin
                op         = OP_UNL_RD;
                state_next = S_UNL_WR;
            end
            S_UNL_WR: begin
                op         = OP_UNL_WR;
                state_next = stat.kind_free ? S_MRG_RD : S_SPLIT;
            end
            S_SPLIT: begin
                if (stat.split_more) begin
                    op         = OP_SPLIT;
                    state_next = S_PUSH_A;
                end else begin
                    op         = OP_ST_RES;
                    state_next = S_OUT;
                end
            end
            S_PUSH_A: begin
                op         = OP_PUSH_A;
                state_next = S_PUSH_B;
            end
            S_PUSH_B: begin
                op = OP_PUSH_B;
                if (!stat.kind_init && !stat.kind_free) state_next = S_SPLIT;
                else state_next = S_OUT;
            end
            S_FCHK0: begin
                if (stat.tag_nz) begin
                    op         = OP_ST_ERR2;
                    state_next = S_OUT;
                end else begin
                    state_next = S_FCHK_RD;
                end
            end
            S_FCHK_RD: begin
                if (stat.k_end) begin
                    op         = OP_MERGE_INIT;
                    state_next = S_MRG_RD;
                end else begin
                    op         = OP_FCHK_READ;
                    state_next = S_FCHK_TST;
                end
            end
            S_FCHK_TST: begin
                if (stat.tag_hit) begin
                    op         = OP_ST_ERR2;
                    state_next = S_OUT;
                end else begin
                    op         = OP_K_INC;
                    state_next = S_FCHK_RD;
                end
            end
            S_MRG_RD: begin
                if (stat.k_last) begin
                    op         = OP_PUSH_SET;
                    state_next = S_PUSH_A;
                end else begin
                    op         = OP_MRG_READ;
                    state_next = S_MRG_TST;
                end
            end
            S_MRG_TST: begin
                if (stat.tag_hit) begin
                    op         = OP_MRG_TAKE;
                    state_next = S_UNL_RD;
                end else begin
                    op         = OP_PUSH_SET;
                    state_next = S_PUSH_A;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    op         = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output word valid flag
    always_comb begin
        if (op == OP_EMIT) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
        else m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR_RST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign cmd.op  = op;

endmodule

[sv/bba_dp.sv]
module bba_dp
    import bba_pkg::*;
#(
    parameter int MIN_BLOCK_LOG2 = 4,
    parameter int MAX_ORDERS     = 13,
    parameter int MAX_HEAP_LOG2  = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cmd_t             cmd,
    output stat_t            stat,
    input  in_word_t         s_data,
    output out_word_t        m_data,
    input  logic             cfg_wr,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int BLK_W  = MAX_HEAP_LOG2 - MIN_BLOCK_LOG2;
    localparam int NBLK   = 1 << BLK_W;
    localparam int LINK_W = BLK_W + 1;
    localparam int TAG_W  = $clog2(MAX_ORDERS + 1);
    localparam int HI_W   = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int HB_W   = MAX_HEAP_LOG2 + 1;
    localparam int CW     = (HB_W > 18) ? HB_W : 18;
    localparam logic [ORD_W-1:0] MIN_O = ORD_W'(MIN_BLOCK_LOG2);
    localparam logic [ORD_W-1:0] MAXH_O = ORD_W'(MAX_HEAP_LOG2);
    localparam logic [ORD_W-1:0] MAXO_O = ORD_W'(MAX_ORDERS);

    // control state
    logic [CFG_W-1:0] cfg_reg;
    logic [ORD_W-1:0] orders_reg;
    logic [ORD_W-1:0] hlog_reg;
    logic [LINK_W-1:0] head_reg [MAX_ORDERS];
    logic [BLK_W-1:0] clr_reg;

    // item working registers
    logic [1:0]        kind_reg;
    logic [16:0]       req_reg;
    logic [15:0]       off_reg;
    logic [ORD_W-1:0]  so_reg, fo_reg, k_reg, uo_reg, po_reg;
    logic [BLK_W-1:0]  b_reg, u_reg, pb_reg;
    logic [LINK_W-1:0] hs_reg;
    logic [1:0]        st_reg;
    logic [15:0]       res_reg;
    out_word_t         out_reg;

    // memory ports
    logic              tag_we, next_we, prev_we;
    logic [BLK_W-1:0]  tag_wa, tag_ra, next_wa, prev_wa;
    logic [TAG_W-1:0]  tag_wd, tag_rd;
    logic [LINK_W-1:0] next_wd, next_rd, prev_wd, prev_rd;

    // derived values
    logic [ORD_W-1:0]  hd_idx;
    logic [LINK_W-1:0] hd;
    logic [CW-1:0]     heap_bytes;
    logic              req_big, off_big, misalign;
    logic [31:0]       amask32;
    logic [BLK_W-1:0]  b_of_off, a_addr, bud, split_blk;
    logic [BLK_W:0]    amask, kbit, kbit_m1;
    logic [ORD_W-1:0]  km1, so_in, ao_in, lc, nc;
    logic [ORD_W:0]    k_p1, n_raw;
    logic [MAX_HEAP_LOG2-1:0] b_bytes;

    // size in bytes to block order
    function automatic logic [ORD_W-1:0] to_order(input logic [16:0] x);
        logic [ORD_W-1:0] c;
        c = ceil_log2(x);
        return (c > MIN_O) ? c - MIN_O : '0;
    endfunction

    assign so_in = to_order(s_data.request_size);
    assign ao_in = (s_data.kind == KIND_ALIGN) ? to_order(s_data.align_size) : '0;

    // init geometry from the heap size register
    always_comb begin
        if (ORD_W'(cfg_reg) < MIN_O) lc = MIN_O;
        else if (ORD_W'(cfg_reg) > MAXH_O) lc = MAXH_O;
        else lc = ORD_W'(cfg_reg);
        n_raw = {1'b0, lc - MIN_O} + 1'b1;
        nc    = (n_raw > {1'b0, MAXO_O}) ? MAXO_O : n_raw[ORD_W-1:0];
    end

    // list head read, one place at a time
    assign hd_idx = (cmd.op == OP_PUSH_A) ? po_reg : k_reg;
    assign hd     = head_reg[hd_idx[HI_W-1:0]];

    // range and alignment checks
    assign heap_bytes = (orders_reg == '0) ? '0 : (CW'(1) << hlog_reg);
    assign req_big    = CW'(req_reg) > heap_bytes;
    assign off_big    = CW'(off_reg) >= heap_bytes;
    assign amask32    = (32'd1 << (so_reg + MIN_O)) - 32'd1;
    assign misalign   = (off_reg & amask32[15:0]) != 16'd0;

    // block address arithmetic
    assign b_of_off  = BLK_W'(off_reg >> MIN_BLOCK_LOG2);
    assign amask     = ((BLK_W + 1)'(1) << k_reg) - 1'b1;
    assign a_addr    = b_reg & ~amask[BLK_W-1:0];
    assign kbit      = (BLK_W + 1)'(1) << k_reg;
    assign bud       = b_reg ^ kbit[BLK_W-1:0];
    assign km1       = k_reg - 1'b1;
    assign kbit_m1   = (BLK_W + 1)'(1) << km1;
    assign split_blk = b_reg + kbit_m1[BLK_W-1:0];
    assign k_p1      = {1'b0, k_reg} + 1'b1;
    assign b_bytes   = {b_reg, {MIN_BLOCK_LOG2{1'b0}}};

    // status to controller
    always_comb begin
        stat.kind_init  = (kind_reg == KIND_INIT);
        stat.kind_free  = (kind_reg == KIND_FREE);
        stat.alloc_bad  = (req_reg == '0) || req_big || (fo_reg >= orders_reg);
        stat.free_bad   = (orders_reg == '0) || (req_reg == '0) || req_big ||
                          (so_reg >= orders_reg) || off_big || misalign;
        stat.k_end      = (k_reg >= orders_reg);
        stat.k_last     = (k_p1 >= {1'b0, orders_reg});
        stat.head_nz    = (hd != '0);
        stat.tag_nz     = (tag_rd != '0);
        stat.tag_hit    = ((ORD_W + 1)'(tag_rd) == k_p1);
        stat.split_more = (k_reg > so_reg);
        stat.clr_last   = (clr_reg == {BLK_W{1'b1}});
    end

    // tag store ports
    always_comb begin
        tag_we = 1'b0;
        tag_wa = u_reg;
        tag_wd = '0;
        case (cmd.op)
            OP_CLR: begin
                tag_we = 1'b1;
                tag_wa = clr_reg;
            end
            OP_PUSH_A: begin
                tag_we = 1'b1;
                tag_wa = pb_reg;
                tag_wd = TAG_W'(po_reg + 1'b1);
            end
            OP_UNL_WR: begin
                tag_we = 1'b1;
            end
            default: begin
            end
        endcase
        case (cmd.op)
            OP_FREE_SETUP: tag_ra = b_of_off;
            OP_FCHK_READ:  tag_ra = a_addr;
            default:       tag_ra = bud;
        endcase
    end

    // link store ports
    always_comb begin
        next_we = 1'b0;
        next_wa = BLK_W'(prev_rd - 1'b1);
        next_wd = next_rd;
        prev_we = 1'b0;
        prev_wa = BLK_W'(next_rd - 1'b1);
        prev_wd = prev_rd;
        case (cmd.op)
            OP_PUSH_A: begin
                next_we = 1'b1;
                next_wa = pb_reg;
                next_wd = hd;
                prev_we = 1'b1;
                prev_wa = pb_reg;
                prev_wd = '0;
            end
            OP_PUSH_B: begin
                prev_we = (hs_reg != '0);
                prev_wa = BLK_W'(hs_reg - 1'b1);
                prev_wd = {1'b0, pb_reg} + 1'b1;
            end
            OP_UNL_WR: begin
                next_we = (prev_rd != '0);
                prev_we = (next_rd != '0);
            end
            default: begin
            end
        endcase
    end

    bba_ram #(.WIDTH(TAG_W), .DEPTH(NBLK)) u_tag (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (tag_wa),
        .wdata (tag_wd),
        .raddr (tag_ra),
        .rdata (tag_rd)
    );

    bba_ram #(.WIDTH(LINK_W), .DEPTH(NBLK)) u_next (
        .aclk  (aclk),
        .we    (next_we),
        .waddr (next_wa),
        .wdata (next_wd),
        .raddr (u_reg),
        .rdata (next_rd)
    );

    bba_ram #(.WIDTH(LINK_W), .DEPTH(NBLK)) u_prev (
        .aclk  (aclk),
        .we    (prev_we),
        .waddr (prev_wa),
        .wdata (prev_wd),
        .raddr (u_reg),
        .rdata (prev_rd)
    );

    // heap geometry, list heads, clearing counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg    <= CFG_W'(16);
            orders_reg <= '0;
            hlog_reg   <= '0;
            clr_reg    <= '0;
            for (int i = 0; i < MAX_ORDERS; i++) head_reg[i] <= '0;
        end else begin
            if (cfg_wr) cfg_reg <= cfg_data;
            case (cmd.op)
                OP_INIT_SETUP: begin
                    orders_reg <= nc;
                    hlog_reg   <= lc;
                    clr_reg    <= '0;
                    for (int i = 0; i < MAX_ORDERS; i++) head_reg[i] <= '0;
                end
                OP_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                end
                OP_PUSH_A: begin
                    head_reg[po_reg[HI_W-1:0]] <= {1'b0, pb_reg} + 1'b1;
                end
                OP_UNL_WR: begin
                    if (prev_rd == '0) head_reg[uo_reg[HI_W-1:0]] <= next_rd;
                end
                default: begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                kind_reg <= s_data.kind;
                req_reg  <= s_data.request_size;
                off_reg  <= s_data.block_offset;
                so_reg   <= so_in;
                fo_reg   <= (so_in >= ao_in) ? so_in : ao_in;
                st_reg   <= ST_OK;
                res_reg  <= '0;
            end
            OP_INIT_SETUP: begin
                pb_reg <= '0;
                po_reg <= nc - 1'b1;
            end
            OP_ALLOC_SETUP: k_reg <= fo_reg;
            OP_K_INC:       k_reg <= k_reg + 1'b1;
            OP_TAKE: begin
                u_reg  <= BLK_W'(hd - 1'b1);
                b_reg  <= BLK_W'(hd - 1'b1);
                uo_reg <= k_reg;
            end
            OP_SPLIT: begin
                k_reg  <= km1;
                pb_reg <= split_blk;
                po_reg <= km1;
            end
            OP_PUSH_A: hs_reg <= hd;
            OP_FREE_SETUP: begin
                b_reg <= b_of_off;
                k_reg <= so_reg + 1'b1;
            end
            OP_MERGE_INIT: k_reg <= so_reg;
            OP_MRG_TAKE: begin
                u_reg  <= bud;
                uo_reg <= k_reg;
                b_reg  <= (bud < b_reg) ? bud : b_reg;
                k_reg  <= k_reg + 1'b1;
            end
            OP_PUSH_SET: begin
                pb_reg <= b_reg;
                po_reg <= k_reg;
            end
            OP_ST_ERR1: st_reg <= ST_NOBLK;
            OP_ST_ERR2: st_reg <= ST_BADFREE;
            OP_ST_RES:  res_reg <= 16'(b_bytes);
            OP_EMIT: begin
                out_reg.status        <= st_reg;
                out_reg.result_offset <= res_reg;
            end
            default: begin
            end
        endcase
    end

    assign m_data = out_reg;

endmodule

[sv/buddy_block_allocator.sv]
// Buddy allocator over a power-of-two heap of minimum-size blocks.
// Input channel s_valid/s_ready/s_data carries one request word: allocate,
// aligned allocate, free or init. Each request gives exactly one result word
// (status, result_offset) on m_valid/m_ready/m_data.
// cfg_valid/cfg_ready/cfg_data write the heap size log2; it is taken at init.
// After reset the block first clears the free-order tag store, one entry per
// cycle, all 2**(MAX_HEAP_LOG2 - MIN_BLOCK_LOG2) entries (4096 by default), with
// s_ready low. Until an init arrives no block is free.
// An init repeats that clearing pass over the whole tag store.
// Other requests then pass through decode, a search over the orders, a check
// of each higher order on a free, and split steps on an allocation or merge
// steps on a free, which use the link stores (one read and one write each per
// cycle); the order walk runs up to MAX_ORDERS steps. s_ready returns as the
// result word is registered.
// One request is worked at a time. The result sits in an output register; a
// new request is accepted while it waits, and if m_ready stays low the next
// result is held back until the register is free.
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int MIN_BLOCK_LOG2 = 4,
    parameter int MAX_ORDERS     = 13,
    parameter int MAX_HEAP_LOG2  = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_word_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_word_t        m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // configuration word taken at any time
    assign cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bba_dp #(
        .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2),
        .MAX_ORDERS     (MAX_ORDERS),
        .MAX_HEAP_LOG2  (MAX_HEAP_LOG2)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_data   (s_data),
        .m_data   (m_data),
        .cfg_wr   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data)
    );

endmodule
